### hdl/assert_macros.svh
// Assertion macros used by the checker file of the 1-Wire master.
// Depends on nothing; every macro expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk_i, switched off while rst_ni is low.
`define OWB_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("owb assertion failed");

// Implication from a condition to a property in the next cycle.
`define OWB_ASSERT_NEXT(label, cond, prop) \
  `OWB_ASSERT(label, (cond) |=> (prop))

`endif

### hdl/owb_pkg.sv
// Package of the 1-Wire master: codes, register indexes, reset values and
// the structs passed between the modules. Depends on nothing.
package owb_pkg;

  localparam int unsigned CFG_W         = 10;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned BIT_IDX_W     = $clog2(BITS_PER_BYTE);

  localparam logic [CFG_W-1:0] RST_RESET_LOW    = 10'd500;
  localparam logic [CFG_W-1:0] RST_PRES_WAIT    = 10'd70;
  localparam logic [CFG_W-1:0] RST_RECOVERY     = 10'd500;
  localparam logic [CFG_W-1:0] RST_SLOT_START   = 10'd5;
  localparam logic [CFG_W-1:0] RST_WRITE_HOLD   = 10'd55;
  localparam logic [CFG_W-1:0] RST_READ_SAMPLE  = 10'd5;
  localparam logic [CFG_W-1:0] RST_READ_TAIL    = 10'd50;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } owb_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESET_LOW   = 3'd0,
    REG_PRES_WAIT   = 3'd1,
    REG_RECOVERY    = 3'd2,
    REG_SLOT_START  = 3'd3,
    REG_WRITE_HOLD  = 3'd4,
    REG_READ_SAMPLE = 3'd5,
    REG_READ_TAIL   = 3'd6
  } owb_reg_e;

  typedef struct packed {
    logic [CFG_W-1:0] reset_low_ticks;
    logic [CFG_W-1:0] presence_wait_ticks;
    logic [CFG_W-1:0] reset_recovery_ticks;
    logic [CFG_W-1:0] slot_start_ticks;
    logic [CFG_W-1:0] write_hold_ticks;
    logic [CFG_W-1:0] read_sample_ticks;
    logic [CFG_W-1:0] read_tail_ticks;
  } owb_cfg_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       presence_bit;
    logic       rejected;
  } owb_res_t;

endpackage

### hdl/owb_if.sv
// Valid/ready channel interfaces of the 1-Wire master: tick input and result.
// Depends on nothing.
interface owb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] write_data;
  logic       line_level;

  modport source (output valid, output op, output write_data, output line_level,
                  input ready);
  modport sink (input valid, input op, input write_data, input line_level,
                output ready);
endinterface

interface owb_out_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       presence_bit;
  logic       rejected;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output read_data, output presence_bit, output rejected,
                  input ready);
  modport sink (input valid, input drive_low, input busy_res, input done_res,
                input read_data, input presence_bit, input rejected,
                output ready);
endinterface

### hdl/owb_cfg.sv
// Configuration register file of the 1-Wire master: seven slot timings.
// Depends on owb_pkg.
module owb_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [owb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [owb_pkg::CFG_W-1:0]       cfg_data_i,
  output owb_pkg::owb_cfg_t               cfg_o
);
  import owb_pkg::*;

  owb_cfg_t cfg_q;
  owb_cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (owb_reg_e'(cfg_idx_i))
        REG_RESET_LOW:   cfg_d.reset_low_ticks      = cfg_data_i;
        REG_PRES_WAIT:   cfg_d.presence_wait_ticks  = cfg_data_i;
        REG_RECOVERY:    cfg_d.reset_recovery_ticks = cfg_data_i;
        REG_SLOT_START:  cfg_d.slot_start_ticks     = cfg_data_i;
        REG_WRITE_HOLD:  cfg_d.write_hold_ticks     = cfg_data_i;
        REG_READ_SAMPLE: cfg_d.read_sample_ticks    = cfg_data_i;
        REG_READ_TAIL:   cfg_d.read_tail_ticks      = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_ticks      <= RST_RESET_LOW;
      cfg_q.presence_wait_ticks  <= RST_PRES_WAIT;
      cfg_q.reset_recovery_ticks <= RST_RECOVERY;
      cfg_q.slot_start_ticks     <= RST_SLOT_START;
      cfg_q.write_hold_ticks     <= RST_WRITE_HOLD;
      cfg_q.read_sample_ticks    <= RST_READ_SAMPLE;
      cfg_q.read_tail_ticks      <= RST_READ_TAIL;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/owb_core.sv
// Bus sequencer of the 1-Wire master: reset, write and read slot timing.
// Depends on owb_pkg; advances one tick on every accepted input transfer.
module owb_core #(
  parameter int unsigned COUNT_WIDTH = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [1:0]         op_i,
  input  logic [7:0]         write_data_i,
  input  logic               line_level_i,
  input  owb_pkg::owb_cfg_t  cfg_i,
  output owb_pkg::owb_res_t  res_o
);
  import owb_pkg::*;

  localparam int unsigned LimW = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
  localparam logic [COUNT_WIDTH-1:0] CntMax = '1;
  localparam logic [BIT_IDX_W-1:0] LastBit = BIT_IDX_W'(BITS_PER_BYTE - 1);

  typedef enum logic [2:0] {
    PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_REC,
    PH_SLOT_LOW, PH_WR_HOLD, PH_RD_WAIT, PH_RD_TAIL
  } phase_e;

  function automatic logic [COUNT_WIDTH-1:0] lim(input logic [CFG_W-1:0] r);
    logic [LimW-1:0] rx;
    logic [LimW-1:0] mx;
    rx = LimW'(r);
    mx = LimW'(CntMax);
    return (rx > mx) ? COUNT_WIDTH'(mx) : COUNT_WIDTH'(rx);
  endfunction

  phase_e                 phase_q, phase_d, ph;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, cnt, cnt_inc;
  logic [BIT_IDX_W-1:0]   bidx_q, bidx_d, bidx;
  logic [7:0]             shift_q, shift_d, sh;
  owb_op_e                cmd_q, cmd_d;
  logic                   pres_q, pres_d;
  logic [7:0]             rdh_q, rdh_d;
  logic                   start;
  logic                   drive, done;

  always_comb begin
    start   = (phase_q == PH_IDLE) && (owb_op_e'(op_i) != OP_TICK);
    ph      = phase_q;
    cnt     = cnt_q;
    bidx    = bidx_q;
    sh      = shift_q;
    cmd_d   = cmd_q;
    if (start) begin
      cmd_d = owb_op_e'(op_i);
      cnt   = '0;
      bidx  = '0;
      sh    = (owb_op_e'(op_i) == OP_WRITE) ? write_data_i : 8'h00;
      ph    = (owb_op_e'(op_i) == OP_RESET) ? PH_RST_LOW : PH_SLOT_LOW;
    end
    cnt_inc = (cnt == CntMax) ? cnt : cnt + 1'b1;

    phase_d = ph;
    cnt_d   = cnt;
    bidx_d  = bidx;
    shift_d = sh;
    pres_d  = pres_q;
    rdh_d   = rdh_q;
    drive   = 1'b0;
    done    = 1'b0;

    case (ph)
      PH_IDLE: ;
      PH_RST_LOW: begin
        drive = 1'b1;
        cnt_d = cnt_inc;
        if (cnt_inc >= lim(cfg_i.reset_low_ticks)) begin
          phase_d = PH_RST_WAIT;
          cnt_d   = '0;
        end
      end
      PH_RST_WAIT: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= lim(cfg_i.presence_wait_ticks)) begin
          pres_d  = line_level_i;
          phase_d = PH_RST_REC;
          cnt_d   = '0;
        end
      end
      PH_RST_REC: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= lim(cfg_i.reset_recovery_ticks)) begin
          phase_d = PH_IDLE;
          cnt_d   = '0;
          done    = 1'b1;
        end
      end
      PH_SLOT_LOW: begin
        drive = 1'b1;
        cnt_d = cnt_inc;
        if (cnt_inc >= lim(cfg_i.slot_start_ticks)) begin
          cnt_d   = '0;
          phase_d = (cmd_d == OP_WRITE) ? PH_WR_HOLD : PH_RD_WAIT;
        end
      end
      PH_RD_WAIT: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= lim(cfg_i.read_sample_ticks)) begin
          shift_d[bidx] = sh[bidx] | line_level_i;
          phase_d       = PH_RD_TAIL;
          cnt_d         = '0;
        end
      end
      PH_WR_HOLD, PH_RD_TAIL: begin
        if ((ph == PH_WR_HOLD && cnt < lim(cfg_i.write_hold_ticks)) ||
            (ph == PH_RD_TAIL && cnt < lim(cfg_i.read_tail_ticks))) begin
          drive = (ph == PH_WR_HOLD) ? ~sh[bidx] : 1'b0;
          cnt_d = cnt_inc;
        end else begin
          // The released tick that closes the slot.
          cnt_d = '0;
          if (bidx == LastBit) begin
            if (cmd_d == OP_READ) begin
              rdh_d = sh;
            end
            phase_d = PH_IDLE;
            bidx_d  = '0;
            done    = 1'b1;
          end else begin
            bidx_d  = bidx + 1'b1;
            phase_d = PH_SLOT_LOW;
          end
        end
      end
      default: ;
    endcase

    res_o.drive_low    = drive;
    res_o.busy_res     = (ph != PH_IDLE);
    res_o.done_res     = done;
    res_o.read_data    = rdh_d;
    res_o.presence_bit = pres_d;
    res_o.rejected     = (phase_q != PH_IDLE) && (owb_op_e'(op_i) != OP_TICK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      bidx_q  <= '0;
      shift_q <= '0;
      cmd_q   <= OP_TICK;
      pres_q  <= 1'b1;
      rdh_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      bidx_q  <= bidx_d;
      shift_q <= shift_d;
      cmd_q   <= cmd_d;
      pres_q  <= pres_d;
      rdh_q   <= rdh_d;
    end
  end

endmodule

### hdl/onewire_bus_master_unit.sv
// Channel   Dir  Transfer carries
// in_i      in   op, write_data, line_level (one bus tick)
// out_o     out  drive_low, busy_res, done_res, read_data, presence_bit, rejected
// cfg_*     in   register index and 10-bit tick count, one write per cycle
//
// One tick is taken per cycle while ready; its result appears in the
// next cycle, from a result register fed by the sequencer's single-pass logic.
// The input stays ready while the result register is empty or being taken,
// so a stalled result blocks new ticks only until out_o.ready returns.
// Reset sets the sequencer to idle and all timing registers to their defaults.
//
// Top level of the 1-Wire master. Depends on owb_pkg, owb_if, owb_cfg, owb_core.
module onewire_bus_master_unit #(
  parameter int unsigned COUNT_WIDTH = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  owb_in_if.sink                        in_i,
  owb_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [owb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [owb_pkg::CFG_W-1:0]     cfg_data_i
);
  import owb_pkg::*;

  owb_cfg_t cfg;
  owb_res_t res;
  owb_res_t res_q;
  logic     out_valid_q;
  logic     step;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign step       = in_i.valid && in_i.ready;

  owb_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  owb_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .op_i         (in_i.op),
    .write_data_i (in_i.write_data),
    .line_level_i (in_i.line_level),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.drive_low    = res_q.drive_low;
  assign out_o.busy_res     = res_q.busy_res;
  assign out_o.done_res     = res_q.done_res;
  assign out_o.read_data    = res_q.read_data;
  assign out_o.presence_bit = res_q.presence_bit;
  assign out_o.rejected     = res_q.rejected;

endmodule

### hdl/owb_checker.sv
// Port-level checker of the 1-Wire master and its bind to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module owb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       drive_low,
  input logic       busy_res,
  input logic       done_res,
  input logic [7:0] read_data,
  input logic       presence_bit,
  input logic       rejected
);

  logic [12:0] out_word;

  assign out_word = {drive_low, busy_res, done_res, read_data, presence_bit, rejected};

  `OWB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))
  `OWB_ASSERT_NEXT(a_in_to_out, in_valid && in_ready, out_valid)
  `OWB_ASSERT(a_ready_when_empty, !out_valid |-> in_ready)
  `OWB_ASSERT(a_busy_flags, out_valid && (drive_low || rejected || done_res) |-> busy_res)

endmodule

bind onewire_bus_master_unit owb_checker u_owb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_i.valid),
  .in_ready     (in_i.ready),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .drive_low    (out_o.drive_low),
  .busy_res     (out_o.busy_res),
  .done_res     (out_o.done_res),
  .read_data    (out_o.read_data),
  .presence_bit (out_o.presence_bit),
  .rejected     (out_o.rejected)
);
